FILE: hdl/mtso_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtso_pkg
// Shared constants for the minimum-travel segment order unit.
// ----------------------------------------------------------------------------
package mtso_pkg;
	localparam int MAX_SEG_DEF    = 8;
	localparam int COORD_BITS_DEF = 16;
	localparam int COST_W         = 28;
	localparam int IDX_W          = 3;
	localparam logic [COST_W-1:0] COST_ONES = '1;
endpackage

FILE: hdl/min_travel_segment_order_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_travel_segment_order_unit
// Brute-force open-path ordering of line segments, least total gap first.
// ----------------------------------------------------------------------------
// Sequence: segments load at one per cycle; after the last request the search
//   walks every order of n-1 segments, each order costing (n-1) gaps, each
//   found by abs, square, a 26-step root and accumulate on one shared
//   unit, plus a compare and the pivot, swap and reverse steps to the next order.
// Throughput: one search at a time; results leave one per cycle while m_tready
//   is high, then the unit returns to load.
// Reset: arst_n clears count, final mark, best cost and the state machine.
module min_travel_segment_order_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
	input  logic [63:0] s_tdata,
	// tuser: is_final
	input  logic        s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: segment_index[2:0], total_cost[30:3], zero fill [31]
	output logic [31:0] m_tdata,
	output logic        m_tlast
);
	import mtso_pkg::*;

	localparam int MAX_SEGMENTS = MAX_SEG_DEF;
	localparam int COORD_BITS   = COORD_BITS_DEF;

	localparam int CW  = COORD_BITS;
	localparam int DW  = CW + 1;
	localparam int SQW = 2 * DW + 1;
	localparam int RW  = SQW / 2 + 9;
	localparam int RMW = RW + 2;
	localparam int STEPS = (SQW + 1) / 2 + 8;
	localparam int SW  = $clog2(STEPS + 1);
	localparam int NW  = $clog2(MAX_SEGMENTS + 1);

	typedef enum logic [3:0] {
		ST_LOAD, ST_INIT, ST_GAP, ST_SQ, ST_ROOT, ST_ACC, ST_CMP,
		ST_NXT_I, ST_NXT_J, ST_REV, ST_OUT
	} state_t;

	state_t state_q;
	logic signed [CW-1:0] sx_q [MAX_SEGMENTS];
	logic signed [CW-1:0] sy_q [MAX_SEGMENTS];
	logic signed [CW-1:0] ex_q [MAX_SEGMENTS];
	logic signed [CW-1:0] ey_q [MAX_SEGMENTS];
	logic [IDX_W-1:0] cur_q  [MAX_SEGMENTS];
	logic [IDX_W-1:0] best_q [MAX_SEGMENTS];
	logic [NW-1:0] count_q;
	logic [IDX_W-1:0] final_q;
	logic [COST_W-1:0] best_cost_q, run_cost_q;
	logic first_q;
	logic [IDX_W-1:0] j_q, i_q, k_q;
	logic [DW-1:0] ax_q, ay_q;
	logic [SQW-1:0] d2_q;
	logic [RW-1:0] root_q;
	logic [RMW-1:0] rem_q;
	logic [SW-1:0] step_q;
	logic mul_sel_q;
	logic [2*DW-1:0] prod_q;

	// load normalize
	logic signed [CW-1:0] in_sx, in_sy, in_ex, in_ey;
	logic swap;
	always_comb begin
		in_sx = s_tdata[CW-1:0];
		in_sy = s_tdata[16+CW-1:16];
		in_ex = s_tdata[32+CW-1:32];
		in_ey = s_tdata[48+CW-1:48];
		swap  = (in_sy < in_ey) || (in_sy == in_ey && in_sx < in_ex);
	end

	assign s_tready = (state_q == ST_LOAD);

	// gap operands
	logic [IDX_W-1:0] fa, ta;
	logic signed [DW-1:0] dx, dy;
	assign fa = cur_q[j_q];
	assign ta = cur_q[j_q + 1'b1];
	assign dx = DW'(ex_q[fa]) - DW'(sx_q[ta]);
	assign dy = DW'(ey_q[fa]) - DW'(sy_q[ta]);

	// shared squarer, x first then y
	logic [DW-1:0] mul_op;
	logic [2*DW-1:0] sq;
	assign mul_op = mul_sel_q ? ay_q : ax_q;
	assign sq = mul_op * mul_op;

	// root step
	logic [1:0] pair;
	logic [RMW-1:0] rem_sh, trial;
	logic [SW-1:0] pi;
	always_comb begin
		pi = SW'(STEPS - 1) - step_q;
		pair = '0;
		if (pi >= SW'(8))
			pair = 2'(d2_q >> (2 * (pi - SW'(8))));
		rem_sh = {rem_q[RMW-3:0], pair};
		trial  = {root_q[RMW-3:0], 2'b01};
	end

	logic [COST_W:0] acc_sum;
	assign acc_sum = {1'b0, run_cost_q} + (COST_W+1)'(root_q);

	logic [NW-1:0] m;   // permuted length n-1
	assign m = count_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			final_q <= '0;
			best_cost_q <= COST_ONES;
			run_cost_q <= '0;
			m_tvalid <= 1'b0;
			first_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: if (s_tvalid) begin
					if (count_q < NW'(MAX_SEGMENTS)) begin
						sx_q[count_q[IDX_W-1:0]] <= swap ? in_ex : in_sx;
						sy_q[count_q[IDX_W-1:0]] <= swap ? in_ey : in_sy;
						ex_q[count_q[IDX_W-1:0]] <= swap ? in_sx : in_ex;
						ey_q[count_q[IDX_W-1:0]] <= swap ? in_sy : in_ey;
						if (s_tuser)
							final_q <= count_q[IDX_W-1:0];
						count_q <= count_q + 1'b1;
					end
					if (s_tlast)
						state_q <= ST_INIT;
				end
				ST_INIT: begin
					if (NW'(final_q) >= count_q)
						final_q <= '0;
					for (int i = 0; i < MAX_SEGMENTS; i++) begin
						logic [IDX_W-1:0] f;
						f = (NW'(final_q) >= count_q) ? '0 : final_q;
						if (NW'(i) == m)
							cur_q[i] <= f;
						else
							cur_q[i] <= (IDX_W'(i) < f) ? IDX_W'(i) : IDX_W'(i + 1);
					end
					first_q <= 1'b1;
					j_q <= '0;
					run_cost_q <= '0;
					state_q <= (count_q < NW'(2)) ? ST_CMP : ST_GAP;
				end
				ST_GAP: begin
					ax_q <= dx[DW-1] ? DW'(-dx) : DW'(dx);
					ay_q <= dy[DW-1] ? DW'(-dy) : DW'(dy);
					mul_sel_q <= 1'b0;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (!mul_sel_q) begin
						prod_q <= sq;
						mul_sel_q <= 1'b1;
					end else begin
						d2_q <= SQW'(prod_q) + SQW'(sq);
						root_q <= '0;
						rem_q <= '0;
						step_q <= '0;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (rem_sh >= trial) begin
						rem_q <= rem_sh - trial;
						root_q <= {root_q[RW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						root_q <= {root_q[RW-2:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == SW'(STEPS - 1))
						state_q <= ST_ACC;
				end
				ST_ACC: begin
					run_cost_q <= acc_sum[COST_W] ? COST_ONES : acc_sum[COST_W-1:0];
					j_q <= j_q + 1'b1;
					state_q <= (NW'(j_q) + NW'(2) < count_q) ? ST_GAP : ST_CMP;
				end
				ST_CMP: begin
					if (first_q || run_cost_q < best_cost_q) begin
						best_cost_q <= run_cost_q;
						for (int i = 0; i < MAX_SEGMENTS; i++)
							best_q[i] <= cur_q[i];
					end
					first_q <= 1'b0;
					if (m < NW'(2)) begin
						k_q <= '0;
						state_q <= ST_OUT;
					end else begin
						i_q <= IDX_W'(m - 1'b1);
						state_q <= ST_NXT_I;
					end
				end
				ST_NXT_I: begin
					// find pivot i: cur[i-1] < cur[i]
					if (i_q == '0) begin
						k_q <= '0;
						state_q <= ST_OUT;
					end else if (cur_q[i_q - 1'b1] < cur_q[i_q]) begin
						k_q <= IDX_W'(m - 1'b1);
						state_q <= ST_NXT_J;
					end else begin
						i_q <= i_q - 1'b1;
					end
				end
				ST_NXT_J: begin
					if (cur_q[k_q] > cur_q[i_q - 1'b1]) begin
						cur_q[k_q] <= cur_q[i_q - 1'b1];
						cur_q[i_q - 1'b1] <= cur_q[k_q];
						k_q <= IDX_W'(m - 1'b1);
						state_q <= ST_REV;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				ST_REV: begin
					if (i_q < k_q) begin
						cur_q[i_q] <= cur_q[k_q];
						cur_q[k_q] <= cur_q[i_q];
						i_q <= i_q + 1'b1;
						k_q <= k_q - 1'b1;
					end else begin
						j_q <= '0;
						run_cost_q <= '0;
						state_q <= ST_GAP;
					end
				end
				ST_OUT: begin
					if (!m_tvalid || m_tready) begin
						if (m_tvalid && m_tlast) begin
							m_tvalid <= 1'b0;
							count_q <= '0;
							final_q <= '0;
							run_cost_q <= '0;
							best_cost_q <= COST_ONES;
							state_q <= ST_LOAD;
						end else begin
							m_tvalid <= 1'b1;
							m_tdata <= {1'b0, best_cost_q, best_q[k_q]};
							m_tlast <= (NW'(k_q) + 1'b1 == count_q);
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ready_only_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("input ready while results pending");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(MAX_SEGMENTS)) else $error("segment count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && m_tvalid)
		else $error("result changed under stall");
`endif
endmodule
